>>> sv/sha512_pkg.sv
// ----------------------------------------------------------------------------
// SHA-512 package
// Shared types and constants for the SHA-512 hash engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        digest_last;
  } sha_out_t;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned BlockWords = 16;
  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [63:0] round_k(input logic [6:0] idx);
    logic [63:0] k;
    case (idx)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] init_hash(input logic [2:0] idx);
    logic [63:0] h;
    case (idx)
      3'd0: h = 64'h6a09e667f3bcc908;
      3'd1: h = 64'hbb67ae8584caa73b;
      3'd2: h = 64'h3c6ef372fe94f82b;
      3'd3: h = 64'ha54ff53a5f1d36f1;
      3'd4: h = 64'h510e527fade682d1;
      3'd5: h = 64'h9b05688c2b3e6c1f;
      3'd6: h = 64'h1f83d9abfb41bd6b;
      default: h = 64'h5be0cd19137e2179;
    endcase
    return h;
  endfunction

endpackage

>>> sv/sha512_hash_engine.sv
// ----------------------------------------------------------------------------
// SHA-512 hash engine
// Buffers message words into 128-byte blocks, pads the final block with the
// bit length, runs the 80-round compression and streams out the digest.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one 64-bit message word per handshake, big
//   endian, with valid_bytes and end_of_message. The result channel carries
//   the eight digest words, H0 first, with digest_last on the eighth.
//   The sixteenth word of a block starts a compression of 80 rounds at one
//   round per cycle on a single round unit, followed by a fold of the result
//   into the hash; in_ready is low meanwhile. A final word causes one or two
//   padding blocks, each filled one word per cycle and compressed, after
//   which the eight digest words are offered one per cycle while out_ready
//   is high. A stalled receiver holds the current word; the block accepts
//   no input until all eight are taken.
//   Reset loads the initial hash and empties the block buffer.
// ----------------------------------------------------------------------------
module sha512_hash_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sha512_pkg::sha_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sha512_pkg::sha_out_t out_data
);
  import sha512_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_FOLD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_MSG, PH_FILL, PH_LEN_HI, PH_LEN_LO
  } pad_t;

  state_t      state_r;
  pad_t        pad_r;
  logic        final_r;
  logic [63:0] hash_r [8];
  logic [63:0] wv_r [8];
  logic [63:0] sched_r [16];
  logic [3:0]  wpos_r;
  logic [63:0] bytes_r;
  logic [6:0]  round_r;
  logic [2:0]  oidx_r;

  logic [63:0] w_cur, w_new, s0, s1, t1, t2, a, e;
  logic [63:0] msg_w, msg_mask, push_w;
  logic [3:0]  nb;
  logic [63:0] bytes_sum;
  logic        do_push;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data.digest_word = hash_r[oidx_r];
  assign out_data.digest_last = (oidx_r == 3'd7);

  always_comb begin
    s0 = {sched_r[1][0], sched_r[1][63:1]} ^ {sched_r[1][7:0], sched_r[1][63:8]}
       ^ (sched_r[1] >> 7);
    s1 = {sched_r[14][18:0], sched_r[14][63:19]} ^ {sched_r[14][60:0], sched_r[14][63:61]}
       ^ (sched_r[14] >> 6);
    w_new = s1 + sched_r[9] + s0 + sched_r[0];
    w_cur = (round_r < 7'(BlockWords)) ? sched_r[round_r[3:0]] : w_new;
    a = wv_r[0];
    e = wv_r[4];
    t1 = wv_r[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
       + ((e & wv_r[5]) ^ (~e & wv_r[6])) + round_k(round_r) + w_cur;
    t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
       + ((a & wv_r[1]) ^ (a & wv_r[2]) ^ (wv_r[1] & wv_r[2]));
  end

  always_comb begin
    nb = (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
    msg_mask = (nb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nb[3:0], 3'b000});
    msg_w = (in_data.message_word & msg_mask)
          | ({PadByte, 56'd0} >> {nb[3:0], 3'b000});
    bytes_sum = bytes_r + (in_data.end_of_message ? 64'(nb) : 64'd8);
    do_push = 1'b0;
    push_w = in_data.message_word;
    if (state_r == ST_IDLE) begin
      do_push = in_valid;
      if (in_data.end_of_message && nb != 4'd8) begin
        push_w = msg_w;
      end
    end else if (state_r == ST_PAD) begin
      do_push = 1'b1;
      case (pad_r)
        PH_MSG:    push_w = {PadByte, 56'd0};
        PH_LEN_HI: push_w = {61'd0, bytes_r[63:61]};
        PH_LEN_LO: push_w = {bytes_r[60:0], 3'b000};
        default:   push_w = 64'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pad_r   <= PH_MSG;
      final_r <= 1'b0;
      wpos_r  <= '0;
      bytes_r <= '0;
      round_r <= '0;
      oidx_r  <= '0;
      for (int i = 0; i < 8; i++) hash_r[i] <= init_hash(3'(i));
    end else begin
      if (do_push) begin
        sched_r[wpos_r] <= push_w;
        wpos_r <= wpos_r + 4'd1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            bytes_r <= bytes_sum;
            if (in_data.end_of_message) begin
              final_r <= 1'b1;
              if (nb == 4'd8) begin
                pad_r <= PH_MSG;
              end else if (wpos_r == 4'd13) begin
                pad_r <= PH_LEN_HI;
              end else begin
                pad_r <= PH_FILL;
              end
            end
            if (wpos_r == 4'd15) begin
              state_r <= ST_ROUND;
              for (int i = 0; i < 8; i++) wv_r[i] <= hash_r[i];
            end else if (in_data.end_of_message) begin
              state_r <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (pad_r == PH_MSG || pad_r == PH_FILL) begin
            pad_r <= (wpos_r == 4'd13) ? PH_LEN_HI : PH_FILL;
          end else if (pad_r == PH_LEN_HI) begin
            pad_r <= PH_LEN_LO;
          end
          if (wpos_r == 4'd15) begin
            state_r <= ST_ROUND;
            for (int i = 0; i < 8; i++) wv_r[i] <= hash_r[i];
          end
        end
        ST_ROUND: begin
          if (round_r >= 7'(BlockWords)) begin
            for (int i = 0; i < 15; i++) sched_r[i] <= sched_r[i + 1];
            sched_r[15] <= w_new;
          end
          round_r <= round_r + 7'd1;
          wv_r[7] <= wv_r[6];
          wv_r[6] <= wv_r[5];
          wv_r[5] <= wv_r[4];
          wv_r[4] <= wv_r[3] + t1;
          wv_r[3] <= wv_r[2];
          wv_r[2] <= wv_r[1];
          wv_r[1] <= wv_r[0];
          wv_r[0] <= t1 + t2;
          if (round_r == 7'(NumRounds - 1)) begin
            state_r <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + wv_r[i];
          round_r <= '0;
          if (!final_r) begin
            state_r <= ST_IDLE;
          end else if (pad_r == PH_LEN_LO) begin
            state_r <= ST_OUT;
            oidx_r <= '0;
          end else begin
            state_r <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              state_r <= ST_IDLE;
              final_r <= 1'b0;
              pad_r <= PH_MSG;
              bytes_r <= '0;
              for (int i = 0; i < 8; i++) hash_r[i] <= init_hash(3'(i));
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/sha512_checker.sv
// ----------------------------------------------------------------------------
// SHA-512 port checker
// Watches the ports of the hash engine for ordering and handshake rules.
// ----------------------------------------------------------------------------
module sha512_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input sha512_pkg::sha_out_t out_data
);
  import sha512_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while digest pending");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("input word withdrawn");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digest word changed under stall");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.digest_last |=> !out_valid)
    else $error("digest continued after last word");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("digest offered after reset");

endmodule

bind sha512_hash_engine sha512_checker u_sha512_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
